/* hw/rtl/mmc_pkg.sv */
// ---------------------------------------------------------------------------
// Mix-minus clip mixer package
// Shared widths, register indexes and the clipping adder.
// ---------------------------------------------------------------------------
`default_nettype none

package mmc_pkg;

  localparam int unsigned NumSources = 8;
  localparam int unsigned SampleW    = 16;
  localparam int unsigned MaskW      = 8;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned DestW      = 3;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [SampleW:0]   wide_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgEnabledMask = 2'd0,
    CfgMutedMask   = 2'd1,
    CfgSumEnable   = 2'd2
  } cfg_idx_e;

  localparam wide_t ClipHi = 17'sd32767;
  localparam wide_t ClipLo = -17'sd32767;

  // One add followed by a hard clip to the symmetric range.
  function automatic sample_t clip_add(sample_t a, sample_t b);
    wide_t s;
    s = {a[SampleW-1], a} + {b[SampleW-1], b};
    if (s >= ClipHi) begin
      s = ClipHi;
    end else if (s <= ClipLo) begin
      s = ClipLo;
    end
    return s[SampleW-1:0];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/mmc_in_if.sv */
// ---------------------------------------------------------------------------
// Mix-minus clip mixer input channel
// One word per sample time: the base sample and one sample per source.
// ---------------------------------------------------------------------------
`default_nettype none

interface mmc_in_if;
  logic            valid;
  logic            ready;
  mmc_pkg::sample_t base_sample;
  mmc_pkg::sample_t src0_sample;
  mmc_pkg::sample_t src1_sample;
  mmc_pkg::sample_t src2_sample;
  mmc_pkg::sample_t src3_sample;
  mmc_pkg::sample_t src4_sample;
  mmc_pkg::sample_t src5_sample;
  mmc_pkg::sample_t src6_sample;
  mmc_pkg::sample_t src7_sample;

  modport source (
    output valid, base_sample, src0_sample, src1_sample, src2_sample, src3_sample,
           src4_sample, src5_sample, src6_sample, src7_sample,
    input  ready
  );
  modport sink (
    input  valid, base_sample, src0_sample, src1_sample, src2_sample, src3_sample,
           src4_sample, src5_sample, src6_sample, src7_sample,
    output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/mmc_out_if.sv */
// ---------------------------------------------------------------------------
// Mix-minus clip mixer output channel
// One word per mixed result.
// ---------------------------------------------------------------------------
`default_nettype none

interface mmc_out_if;
  logic                             valid;
  logic                             ready;
  logic [mmc_pkg::DestW-1:0]        dest_index;
  logic                             is_sum;
  mmc_pkg::sample_t                 mixed_sample;
  logic                             last;

  modport source (
    output valid, dest_index, is_sum, mixed_sample, last,
    input  ready
  );
  modport sink (
    input  valid, dest_index, is_sum, mixed_sample, last,
    output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/mix_minus_clip_mixer_core.sv */
// ---------------------------------------------------------------------------
// Mix-minus clip mixer core
// N-minus-one conference mixer with per-add hard clipping.
// ---------------------------------------------------------------------------
// Each input word is one sample time. One lane per source plus one total-mix
// lane run side by side through a NUM_SOURCES-stage pipeline, stage k adding
// source k with clipping, so a new word can enter every cycle unless the
// pipeline holds, and it passes through every stage to the merge stage. The
// merge stage then sends one result word per cycle while the output is ready:
// a sample time gives one word per result (enabled sources, plus one when the
// total mix is on; up to NUM_SOURCES + 1), and a word with no enabled source
// gives nothing. Input is accepted while the merge stage still drains the
// previous sample time. Change the masks only when no word is in flight.
// ---------------------------------------------------------------------------
`default_nettype none

module mix_minus_clip_mixer_core #(
  parameter int unsigned NUM_SOURCES = mmc_pkg::NumSources
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [mmc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [mmc_pkg::MaskW-1:0]   cfg_data_i,
  mmc_in_if.sink                           src_i,
  mmc_out_if.source                        res_o
);

  localparam int unsigned NumLanes = NUM_SOURCES + 1;

  logic [mmc_pkg::MaskW-1:0] en_mask_q;
  logic [mmc_pkg::MaskW-1:0] mute_mask_q;
  logic                      sum_en_q;

  logic [NUM_SOURCES-1:0] en;
  logic [NUM_SOURCES-1:0] active;
  logic [NUM_SOURCES:0]   emit;

  mmc_pkg::sample_t in_smp    [mmc_pkg::NumSources];
  mmc_pkg::sample_t smp_q     [NUM_SOURCES][NUM_SOURCES];
  mmc_pkg::sample_t stage_smp [NUM_SOURCES];
  mmc_pkg::sample_t lane_res  [NumLanes];

  logic [NUM_SOURCES-1:0] vld_q;
  logic                   adv;
  logic                   merge_ready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_mask_q   <= '0;
      mute_mask_q <= '0;
      sum_en_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mmc_pkg::CfgEnabledMask: en_mask_q   <= cfg_data_i;
        mmc_pkg::CfgMutedMask:   mute_mask_q <= cfg_data_i;
        mmc_pkg::CfgSumEnable:   sum_en_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign en     = en_mask_q[NUM_SOURCES-1:0];
  assign active = en & ~mute_mask_q[NUM_SOURCES-1:0];
  assign emit   = {sum_en_q && (en != '0), en};

  assign in_smp[0] = src_i.src0_sample;
  assign in_smp[1] = src_i.src1_sample;
  assign in_smp[2] = src_i.src2_sample;
  assign in_smp[3] = src_i.src3_sample;
  assign in_smp[4] = src_i.src4_sample;
  assign in_smp[5] = src_i.src5_sample;
  assign in_smp[6] = src_i.src6_sample;
  assign in_smp[7] = src_i.src7_sample;

  // The whole pipeline moves together; it holds only when the last stage
  // carries a word that the merge stage cannot take yet.
  assign adv         = !vld_q[NUM_SOURCES-1] || merge_ready;
  assign src_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= (vld_q << 1) | NUM_SOURCES'(src_i.valid);
    end
  end

  // Samples travel with the word so that stage k sees source k of its word.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j < NUM_SOURCES; j++) begin
        smp_q[0][j] <= in_smp[j];
      end
      for (int s = 1; s < NUM_SOURCES; s++) begin
        smp_q[s] <= smp_q[s-1];
      end
    end
  end

  for (genvar k = 0; k < NUM_SOURCES; k++) begin : g_smp
    if (k == 0) begin : g_first
      assign stage_smp[k] = in_smp[0];
    end else begin : g_next
      assign stage_smp[k] = smp_q[k-1][k];
    end
  end

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    mmc_lane #(
      .NUM_SOURCES (NUM_SOURCES),
      .LANE_IDX    (l)
    ) u_lane (
      .clk_i       (clk_i),
      .adv_i       (adv),
      .base_i      (src_i.base_sample),
      .stage_smp_i (stage_smp),
      .active_i    (active),
      .acc_o       (lane_res[l])
    );
  end

  mmc_merge #(
    .NUM_SOURCES (NUM_SOURCES)
  ) u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (vld_q[NUM_SOURCES-1]),
    .in_ready_o (merge_ready),
    .lane_res_i (lane_res),
    .emit_i     (emit),
    .res_o      (res_o)
  );

  // A word stalled in the last stage must not be dropped.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NUM_SOURCES-1] && !merge_ready |=> vld_q[NUM_SOURCES-1])
    else $error("stalled word lost from the last pipeline stage");

  // A sample time that still has results keeps the output valid.
  a_burst_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.ready && !res_o.last |=> res_o.valid)
    else $error("result burst ended before its last word");

  // The total mix is the final word and names no destination.
  a_sum_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.is_sum |-> res_o.last && (res_o.dest_index == '0))
    else $error("total mix word is not the final word of its sample time");

endmodule

`default_nettype wire

/* hw/rtl/mmc_lane.sv */
// ---------------------------------------------------------------------------
// Mix-minus clip mixer lane
// Pipelined clip-add chain for one destination or the total mix; stage k adds source k when it is active.
// ---------------------------------------------------------------------------
`default_nettype none

module mmc_lane #(
  parameter int unsigned NUM_SOURCES = mmc_pkg::NumSources,
  parameter int unsigned LANE_IDX    = 0
) (
  input  wire logic             clk_i,
  input  wire logic             adv_i,
  input  wire mmc_pkg::sample_t base_i,
  input  wire mmc_pkg::sample_t stage_smp_i [NUM_SOURCES],
  input  wire logic [NUM_SOURCES-1:0] active_i,
  output mmc_pkg::sample_t      acc_o
);

  mmc_pkg::sample_t acc_q [NUM_SOURCES];
  mmc_pkg::sample_t acc_d [NUM_SOURCES];

  for (genvar k = 0; k < NUM_SOURCES; k++) begin : g_stage
    mmc_pkg::sample_t acc_in;

    if (k == 0) begin : g_first
      assign acc_in = base_i;
    end else begin : g_next
      assign acc_in = acc_q[k-1];
    end

    // The lane's own source is never added to its own mix.
    if (k == LANE_IDX) begin : g_own
      assign acc_d[k] = acc_in;
    end else begin : g_other
      assign acc_d[k] = active_i[k] ? mmc_pkg::clip_add(acc_in, stage_smp_i[k]) : acc_in;
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        acc_q[k] <= acc_d[k];
      end
    end
  end

  assign acc_o = acc_q[NUM_SOURCES-1];

endmodule

`default_nettype wire

/* hw/rtl/mmc_merge.sv */
// ---------------------------------------------------------------------------
// Mix-minus clip mixer merge stage
// Holds the lane results of one sample time and sends them one word a cycle while the output is ready.
// ---------------------------------------------------------------------------
`default_nettype none

module mmc_merge #(
  parameter int unsigned NUM_SOURCES = mmc_pkg::NumSources
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire mmc_pkg::sample_t lane_res_i [NUM_SOURCES+1],
  input  wire logic [NUM_SOURCES:0] emit_i,
  mmc_out_if.source         res_o
);

  localparam int unsigned NumLanes = NUM_SOURCES + 1;
  localparam int unsigned LaneIdxW = $clog2(NumLanes);

  logic [NumLanes-1:0] pend_q;
  mmc_pkg::sample_t    res_q [NumLanes];
  logic [LaneIdxW-1:0] sel;
  logic [NumLanes-1:0] rest;
  logic                fire;
  logic                found;

  // Lowest pending lane goes first, which keeps index order with the sum last.
  always_comb begin
    sel   = '0;
    found = 1'b0;
    for (int i = 0; i < NumLanes; i++) begin
      if (pend_q[i] && !found) begin
        sel   = LaneIdxW'(i);
        found = 1'b1;
      end
    end
  end

  assign rest       = pend_q & ~(NumLanes'(1) << sel);
  assign fire       = res_o.valid && res_o.ready;
  assign in_ready_o = (pend_q == '0) || (fire && (rest == '0));

  assign res_o.valid        = |pend_q;
  assign res_o.mixed_sample = res_q[sel];
  assign res_o.is_sum       = (sel == LaneIdxW'(NUM_SOURCES));
  assign res_o.dest_index   = res_o.is_sum ? '0 : mmc_pkg::DestW'(sel);
  assign res_o.last         = (rest == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_ready_o && in_valid_i) begin
      pend_q <= emit_i;
    end else if (fire) begin
      pend_q <= rest;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      res_q <= lane_res_i;
    end
  end

endmodule

`default_nettype wire

/* test/mix_minus_clip_mixer_core_tb.sv */
// ---------------------------------------------------------------------------
// Mix-minus clip mixer core testbench
// Sends sample-time words under changing mask settings and random
// backpressure. Every mix-minus and total-mix result is predicted and
// compared in order.
// ---------------------------------------------------------------------------

localparam int MixCeil  = 32767;
localparam int MixFloor = -32767;

typedef struct {
  mmc_pkg::sample_t base;
  mmc_pkg::sample_t src [mmc_pkg::NumSources];
} mix_word_t;

typedef struct packed {
  logic [mmc_pkg::DestW-1:0] dest;
  logic                      is_sum;
  mmc_pkg::sample_t          mixed;
  logic                      last;
} mix_result_t;

class mix_tracker;
  logic [mmc_pkg::MaskW-1:0] enabled  = '0;
  logic [mmc_pkg::MaskW-1:0] muted    = '0;
  logic                      total_on = 1'b0;
  mix_result_t               owed [$];
  int unsigned               fails = 0;

  function void write_reg(logic [mmc_pkg::CfgIdxW-1:0] idx, logic [mmc_pkg::MaskW-1:0] data);
    case (idx)
      mmc_pkg::CfgEnabledMask: enabled = data;
      mmc_pkg::CfgMutedMask:   muted = data;
      mmc_pkg::CfgSumEnable:   total_on = data[0];
      default: ;
    endcase
  endfunction

  static function int clip_sum(int acc, int s);
    int r;
    r = acc + s;
    if (r >= MixCeil) begin
      r = MixCeil;
    end
    if (r <= MixFloor) begin
      r = MixFloor;
    end
    return r;
  endfunction

  // Works out every result that one accepted word must produce.
  function void note_word(mix_word_t w);
    logic [mmc_pkg::MaskW-1:0] live;
    int          acc;
    int          count;
    int          k;
    mix_result_t r;
    if (enabled == '0) begin
      return;
    end
    live  = enabled & ~muted;
    count = $countones(enabled) + int'(total_on);
    k     = 0;
    for (int d = 0; d < mmc_pkg::NumSources; d++) begin
      if (enabled[d]) begin
        acc = w.base;
        for (int s = 0; s < mmc_pkg::NumSources; s++) begin
          if (s != d && live[s]) begin
            acc = clip_sum(acc, w.src[s]);
          end
        end
        k++;
        r.dest   = d[mmc_pkg::DestW-1:0];
        r.is_sum = 1'b0;
        r.mixed  = acc[mmc_pkg::SampleW-1:0];
        r.last   = (k == count);
        owed.push_back(r);
      end
    end
    if (total_on) begin
      acc = w.base;
      for (int s = 0; s < mmc_pkg::NumSources; s++) begin
        if (live[s]) begin
          acc = clip_sum(acc, w.src[s]);
        end
      end
      r.dest   = '0;
      r.is_sum = 1'b1;
      r.mixed  = acc[mmc_pkg::SampleW-1:0];
      r.last   = 1'b1;
      owed.push_back(r);
    end
  endfunction

  function void check_mix(mix_result_t got);
    mix_result_t want;
    if (owed.size() == 0) begin
      $error("unexpected word: dest_index %0d is_sum %0b mixed_sample %0d last %0b",
             got.dest, got.is_sum, got.mixed, got.last);
      fails++;
      return;
    end
    want = owed.pop_front();
    if (got.dest !== want.dest) begin
      $error("dest_index: expected %0d, actual %0d", want.dest, got.dest);
      fails++;
    end
    if (got.is_sum !== want.is_sum) begin
      $error("is_sum: expected %0b, actual %0b", want.is_sum, got.is_sum);
      fails++;
    end
    if (got.mixed !== want.mixed) begin
      $error("mixed_sample: expected %0d, actual %0d", want.mixed, got.mixed);
      fails++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0b, actual %0b", want.last, got.last);
      fails++;
    end
  endfunction
endclass

module mix_minus_clip_mixer_core_tb;

  localparam int unsigned RandomItems  = 455;
  localparam int unsigned SettleCycles = 3 * mmc_pkg::NumSources;
  localparam int unsigned CycleLimit   = 400000;
  localparam logic [mmc_pkg::CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam mmc_pkg::sample_t MaxSample = 16'sh7fff;
  localparam mmc_pkg::sample_t MinSample = 16'sh8000;

  logic                        clk_i      = 1'b0;
  logic                        rst_ni     = 1'b0;
  logic                        cfg_we_i   = 1'b0;
  logic [mmc_pkg::CfgIdxW-1:0] cfg_idx_i  = '0;
  logic [mmc_pkg::MaskW-1:0]   cfg_data_i = '0;
  bit                          gaps_on    = 1'b1;
  int unsigned                 cycle_count = 0;
  mix_tracker                  tracker;

  mmc_in_if  in_ch ();
  mmc_out_if out_ch ();

  mix_minus_clip_mixer_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .src_i      (in_ch),
    .res_o      (out_ch)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ch.ready <= gaps_on ? ($urandom_range(0, 99) >= 27) : 1'b1;
  end

  always @(posedge clk_i) begin : watch_results
    mix_result_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.dest   = out_ch.dest_index;
      got.is_sum = out_ch.is_sum;
      got.mixed  = out_ch.mixed_sample;
      got.last   = out_ch.last;
      tracker.check_mix(got);
    end
  end

  function automatic mmc_pkg::sample_t pick_sample();
    case ($urandom_range(0, 9))
      0: return MaxSample;
      1: return MinSample;
      2, 3: return mmc_pkg::sample_t'(int'($urandom_range(0, 400)) - 200);
      default: return mmc_pkg::sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [mmc_pkg::MaskW-1:0] pick_mask();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return mmc_pkg::MaskW'(1 << $urandom_range(0, mmc_pkg::MaskW - 1));
      default: return mmc_pkg::MaskW'($urandom);
    endcase
  endfunction

  function automatic mix_word_t flat_word(mmc_pkg::sample_t base, mmc_pkg::sample_t v);
    mix_word_t w;
    w.base = base;
    foreach (w.src[i]) begin
      w.src[i] = v;
    end
    return w;
  endfunction

  function automatic mix_word_t random_word();
    mix_word_t w;
    w.base = ($urandom_range(0, 3) == 0) ? mmc_pkg::sample_t'(0) : pick_sample();
    foreach (w.src[i]) begin
      w.src[i] = pick_sample();
    end
    return w;
  endfunction

  // Valid is lowered only where a clock edge follows before it can rise again.
  task automatic send_word(input mix_word_t w);
    while (gaps_on && $urandom_range(0, 99) < 27) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.base_sample <= w.base;
    in_ch.src0_sample <= w.src[0];
    in_ch.src1_sample <= w.src[1];
    in_ch.src2_sample <= w.src[2];
    in_ch.src3_sample <= w.src[3];
    in_ch.src4_sample <= w.src[4];
    in_ch.src5_sample <= w.src[5];
    in_ch.src6_sample <= w.src[6];
    in_ch.src7_sample <= w.src[7];
    do @(posedge clk_i); while (!in_ch.ready);
    tracker.note_word(w);
  endtask

  task automatic wait_drained();
    while (tracker.owed.size() != 0) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // A word with no enabled source gives no result, so the pipeline may still
  // hold one after the last result; let it run empty before touching masks.
  task automatic settle();
    wait_drained();
    repeat (SettleCycles) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic program_mixer(input logic [mmc_pkg::MaskW-1:0] en,
                               input logic [mmc_pkg::MaskW-1:0] mu,
                               input logic [mmc_pkg::MaskW-1:0] total_data,
                               input bit poke_unused);
    logic [mmc_pkg::MaskW-1:0] junk;
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= mmc_pkg::CfgEnabledMask;
    cfg_data_i <= en;
    @(posedge clk_i);
    tracker.write_reg(mmc_pkg::CfgEnabledMask, en);
    cfg_idx_i  <= mmc_pkg::CfgMutedMask;
    cfg_data_i <= mu;
    @(posedge clk_i);
    tracker.write_reg(mmc_pkg::CfgMutedMask, mu);
    cfg_idx_i  <= mmc_pkg::CfgSumEnable;
    cfg_data_i <= total_data;
    @(posedge clk_i);
    tracker.write_reg(mmc_pkg::CfgSumEnable, total_data);
    if (poke_unused) begin
      junk       = mmc_pkg::MaskW'($urandom);
      cfg_idx_i  <= CfgUnused;
      cfg_data_i <= junk;
      @(posedge clk_i);
      tracker.write_reg(CfgUnused, junk);
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    mix_word_t   w;
    int unsigned sent;
    int unsigned span;
    int unsigned phase;
    tracker = new();
    in_ch.valid       = 1'b0;
    in_ch.base_sample = '0;
    in_ch.src0_sample = '0;
    in_ch.src1_sample = '0;
    in_ch.src2_sample = '0;
    in_ch.src3_sample = '0;
    in_ch.src4_sample = '0;
    in_ch.src5_sample = '0;
    in_ch.src6_sample = '0;
    in_ch.src7_sample = '0;
    out_ch.ready      = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Registers still hold their reset values, so nothing may come out.
    send_word(flat_word(16'sh1234, -16'sd5));
    send_word(random_word());
    settle();

    program_mixer('1, '0, 8'h01, 1'b0);
    send_word(flat_word(MaxSample, MaxSample));
    send_word(flat_word(MinSample, MinSample));
    send_word(flat_word(MinSample, 16'sd0));
    wait_drained();
    // Saturate high on the first add, then come back down on the next one.
    w = flat_word(MaxSample, 16'sd0);
    w.src[0] = MaxSample;
    w.src[1] = MinSample;
    send_word(w);
    foreach (w.src[i]) begin
      w.src[i] = i[0] ? MaxSample : MinSample;
    end
    send_word(w);
    send_word(random_word());
    settle();

    // A lone source has nothing added, so the base passes through unclipped.
    program_mixer(8'h01, '0, '0, 1'b1);
    send_word(flat_word(MinSample, MaxSample));
    send_word(flat_word(MaxSample, MinSample));
    settle();

    // Every source muted: each mix and the total are the base alone.
    program_mixer('1, '1, '1, 1'b1);
    send_word(flat_word(MinSample, MaxSample));
    send_word(random_word());
    settle();

    program_mixer(8'ha5, 8'h0f, 8'h01, 1'b0);
    repeat (3) send_word(random_word());
    settle();

    // No enabled source: no mixes and no total either.
    program_mixer('0, '0, 8'h01, 1'b1);
    repeat (2) send_word(random_word());
    settle();

    sent  = 0;
    phase = 0;
    while (sent < RandomItems) begin
      gaps_on <= (phase < 3 || phase > 5);
      program_mixer(pick_mask(), pick_mask(), mmc_pkg::MaskW'($urandom),
                    $urandom_range(0, 2) == 0);
      span = $urandom_range(8, 40);
      if (span > RandomItems - sent) begin
        span = RandomItems - sent;
      end
      repeat (span) begin
        if ($urandom_range(0, 59) == 0) begin
          wait_drained();
        end
        send_word(random_word());
        sent++;
      end
      settle();
      phase++;
    end

    if (tracker.fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
